@@ hdl/clnw_pkg.sv @@
// shared types, constants and the control store for the character lcd nibble writer
// no dependencies; used by the channel interfaces and the top level
package clnw_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_CMD   = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_MOVE  = 2'd3
  } req_e;

  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_SHIFT_LEFT  = 8'h18;
  localparam logic [7:0] ROW0_BASE       = 8'h80;
  localparam logic [7:0] ROW1_BASE       = 8'hC0;

  localparam int unsigned CNT_W = 7;
  localparam logic [CNT_W-1:0] SCROLL_START = 7'd16;
  localparam logic [CNT_W-1:0] SCROLL_PAGE  = 7'd41;
  localparam logic [CNT_W-1:0] SCROLL_ROW2  = 7'd56;
  localparam logic [CNT_W-1:0] SCROLL_WRAP  = 7'd80;

  // micro-address width and entry points
  localparam int unsigned UPC_W = 4;
  localparam logic [UPC_W-1:0] UA_CMD     = 4'd0;
  localparam logic [UPC_W-1:0] UA_CLEAR   = 4'd1;
  localparam logic [UPC_W-1:0] UA_MOVE    = 4'd2;
  localparam logic [UPC_W-1:0] UA_DATA    = 4'd3;
  localparam logic [UPC_W-1:0] UA_SHIFT1  = 4'd4;
  localparam logic [UPC_W-1:0] UA_SHIFT16 = 4'd5;
  localparam logic [UPC_W-1:0] UA_WRAP1   = 4'd6;
  localparam logic [UPC_W-1:0] UA_WRAP16  = 4'd7;
  localparam logic [UPC_W-1:0] UA_HOME    = 4'd8;

  // byte source of a control word
  typedef enum logic [2:0] {
    SRC_OPERAND,
    SRC_CLEAR,
    SRC_SHIFT,
    SRC_HOME
  } src_e;

  // how the sequencer leaves a control word
  typedef enum logic [1:0] {
    JMP_END,
    JMP_NEXT,
    JMP_SCROLL
  } jump_e;

  // scroll class of the character count after a data byte
  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_ONE,
    CLS_PAGE,
    CLS_WRAP
  } cls_e;

  typedef struct packed {
    src_e  src;
    logic  rs;
    logic  rep16;
    logic  clr_cnt;
    jump_e jump;
  } uword_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] payload_byte;
    logic       row_sel;
    logic [7:0] column;
  } req_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
  } xfer_t;

  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '{src: SRC_OPERAND, rs: 1'b0, rep16: 1'b0, clr_cnt: 1'b0, jump: JMP_END};
    case (addr)
      UA_CMD:     w = '{SRC_OPERAND, 1'b0, 1'b0, 1'b0, JMP_END};
      UA_CLEAR:   w = '{SRC_CLEAR,   1'b0, 1'b0, 1'b0, JMP_END};
      UA_MOVE:    w = '{SRC_OPERAND, 1'b0, 1'b0, 1'b0, JMP_END};
      UA_DATA:    w = '{SRC_OPERAND, 1'b1, 1'b0, 1'b0, JMP_SCROLL};
      UA_SHIFT1:  w = '{SRC_SHIFT,   1'b0, 1'b0, 1'b0, JMP_END};
      UA_SHIFT16: w = '{SRC_SHIFT,   1'b0, 1'b1, 1'b0, JMP_END};
      UA_WRAP1:   w = '{SRC_SHIFT,   1'b0, 1'b0, 1'b0, JMP_NEXT};
      UA_WRAP16:  w = '{SRC_SHIFT,   1'b0, 1'b1, 1'b0, JMP_NEXT};
      UA_HOME:    w = '{SRC_HOME,    1'b0, 1'b0, 1'b1, JMP_END};
      default:    w = '{SRC_OPERAND, 1'b0, 1'b0, 1'b0, JMP_END};
    endcase
    return w;
  endfunction

endpackage

@@ hdl/clnw_req_if.sv @@
// request channel: valid/ready handshake carrying one lcd request word
// depends on clnw_pkg for the payload type
interface clnw_req_if;
  logic             valid;
  logic             ready;
  clnw_pkg::req_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/clnw_xfer_if.sv @@
// transfer channel: valid/ready handshake carrying one 4-bit bus transfer
// depends on clnw_pkg for the payload type
interface clnw_xfer_if;
  logic             valid;
  logic             ready;
  clnw_pkg::xfer_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/char_lcd_nibble_writer_autoscroll_top.sv @@
// Character LCD 4-bit write interface with autoscroll.
// Requests arrive on in_i (raw command, data byte, clear screen, move cursor);
// bus transfers leave on out_o, one nibble per word, high nibble first,
// with reg_select and a last flag on the final transfer of each request.
// A microcoded sequencer walks a nine-word control store: one control word per
// byte, two transfers per byte, a repeat counter for sixteen-shift bursts and a
// scroll dispatch on the character count after a data byte.
// The first transfer of a request enters the output register once the
// sequencer holds the request and the output register is free. Throughput:
// one transfer per cycle while the receiver does not stall; ordinary requests
// send one byte and a data byte that wraps the display sends up to nineteen.
// The next request is taken as the current one's last transfer is registered.
// Reset clears the character count and empties the sequencer and output
// register. When the receiver stalls, the output register holds its word and
// the sequencer waits; a new request is not taken until the sequence finishes.
// Depends on clnw_pkg, clnw_req_if and clnw_xfer_if.
module char_lcd_nibble_writer_autoscroll_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  clnw_req_if.sink    in_i,
  clnw_xfer_if.source out_o
);

  logic                            busy_q, busy_d;
  logic [clnw_pkg::UPC_W-1:0]      upc_q, upc_d;
  logic                            half_q, half_d;
  logic [3:0]                      rep_q, rep_d;
  logic [clnw_pkg::CNT_W-1:0]      count_q, count_d;
  logic                            out_valid_q, out_valid_d;
  clnw_pkg::xfer_t                 out_q;
  logic [7:0]                      operand_q;

  clnw_pkg::uword_t                uw;
  clnw_pkg::cls_e                  cls;
  logic [7:0]                      cur_byte;
  logic                            adv;
  logic                            word_done;
  logic                            seq_end;
  logic                            accept;
  logic [clnw_pkg::CNT_W-1:0]      count_base;
  logic [7:0]                      row_base;
  logic [clnw_pkg::UPC_W-1:0]      entry;
  clnw_pkg::xfer_t                 xfer;

  always_comb begin
    uw = clnw_pkg::ucode(upc_q);

    // scroll class of the already incremented count
    if (count_q > clnw_pkg::SCROLL_WRAP) begin
      cls = clnw_pkg::CLS_WRAP;
    end else if (count_q > clnw_pkg::SCROLL_ROW2) begin
      cls = clnw_pkg::CLS_ONE;
    end else if (count_q == clnw_pkg::SCROLL_PAGE) begin
      cls = clnw_pkg::CLS_PAGE;
    end else if (count_q > clnw_pkg::SCROLL_START && count_q < clnw_pkg::SCROLL_PAGE) begin
      cls = clnw_pkg::CLS_ONE;
    end else begin
      cls = clnw_pkg::CLS_NONE;
    end

    case (uw.src)
      clnw_pkg::SRC_OPERAND: cur_byte = operand_q;
      clnw_pkg::SRC_CLEAR:   cur_byte = clnw_pkg::CMD_CLEAR;
      clnw_pkg::SRC_SHIFT:   cur_byte = clnw_pkg::CMD_SHIFT_LEFT;
      clnw_pkg::SRC_HOME:    cur_byte = clnw_pkg::ROW0_BASE;
      default:               cur_byte = operand_q;
    endcase

    adv       = busy_q && (!out_valid_q || out_o.ready);
    word_done = half_q && (!uw.rep16 || rep_q == 4'd15);
    seq_end   = word_done && (uw.jump == clnw_pkg::JMP_END ||
                (uw.jump == clnw_pkg::JMP_SCROLL && cls == clnw_pkg::CLS_NONE));

    xfer.reg_select = uw.rs;
    xfer.nibble     = half_q ? cur_byte[3:0] : cur_byte[7:4];
    xfer.last       = seq_end;

    in_i.ready = !busy_q || (adv && seq_end);
    accept     = in_i.valid && in_i.ready;

    case (clnw_pkg::req_e'(in_i.data.req_type))
      clnw_pkg::REQ_CMD:   entry = clnw_pkg::UA_CMD;
      clnw_pkg::REQ_DATA:  entry = clnw_pkg::UA_DATA;
      clnw_pkg::REQ_CLEAR: entry = clnw_pkg::UA_CLEAR;
      clnw_pkg::REQ_MOVE:  entry = clnw_pkg::UA_MOVE;
      default:             entry = clnw_pkg::UA_CMD;
    endcase
    row_base = in_i.data.row_sel ? clnw_pkg::ROW1_BASE : clnw_pkg::ROW0_BASE;

    // sequencer step
    busy_d = busy_q;
    upc_d  = upc_q;
    half_d = half_q;
    rep_d  = rep_q;
    if (adv) begin
      half_d = !half_q;
      if (half_q) begin
        rep_d = word_done ? 4'd0 : rep_q + 4'd1;
      end
      if (word_done) begin
        case (uw.jump)
          clnw_pkg::JMP_NEXT: upc_d = upc_q + 4'd1;
          clnw_pkg::JMP_SCROLL: begin
            case (cls)
              clnw_pkg::CLS_ONE:  upc_d = clnw_pkg::UA_SHIFT1;
              clnw_pkg::CLS_PAGE: upc_d = clnw_pkg::UA_SHIFT16;
              clnw_pkg::CLS_WRAP: upc_d = clnw_pkg::UA_WRAP1;
              default:            upc_d = upc_q;
            endcase
          end
          default: upc_d = upc_q;
        endcase
        if (seq_end) begin
          busy_d = 1'b0;
        end
      end
    end

    // count: wrap clear from the running sequence comes before the new request
    count_base = (adv && word_done && uw.clr_cnt) ? '0 : count_q;
    count_d    = count_base;

    if (accept) begin
      busy_d = 1'b1;
      upc_d  = entry;
      half_d = 1'b0;
      rep_d  = 4'd0;
      case (clnw_pkg::req_e'(in_i.data.req_type))
        clnw_pkg::REQ_DATA:  count_d = count_base + 7'd1;
        clnw_pkg::REQ_CLEAR: count_d = '0;
        default:             count_d = count_base;
      endcase
    end

    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      upc_q       <= clnw_pkg::UA_CMD;
      half_q      <= 1'b0;
      rep_q       <= 4'd0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      upc_q       <= upc_d;
      half_q      <= half_d;
      rep_q       <= rep_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      operand_q <= (in_i.data.req_type == clnw_pkg::REQ_MOVE) ?
                   row_base + in_i.data.column : in_i.data.payload_byte;
    end
    if (adv) begin
      out_q <= xfer;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

@@ sim/char_lcd_nibble_writer_autoscroll_top_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the character lcd nibble writer with autoscroll
// depends on clnw_pkg, clnw_req_if, clnw_xfer_if and char_lcd_nibble_writer_autoscroll_top
module char_lcd_nibble_writer_autoscroll_top_tb;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 330;
  localparam int QUIET_FROM   = 270;
  localparam int LONG_HOLD    = 400;

  // expected bus transfers plus a private copy of the character count
  class lcd_xfer_scoreboard;
    clnw_pkg::xfer_t            expected_xfers[$];
    logic [clnw_pkg::CNT_W-1:0] chars_written = '0;
    int                         errors = 0;

    function void push_byte(logic rs, logic [7:0] b);
      expected_xfers.push_back('{reg_select: rs, nibble: b[7:4], last: 1'b0});
      expected_xfers.push_back('{reg_select: rs, nibble: b[3:0], last: 1'b0});
    endfunction

    function void push_shifts(int count);
      for (int i = 0; i < count; i++) push_byte(1'b0, clnw_pkg::CMD_SHIFT_LEFT);
    endfunction

    function void note_request(clnw_pkg::req_t r);
      logic [clnw_pkg::CNT_W-1:0] n;
      logic [7:0]                 addr;
      case (clnw_pkg::req_e'(r.req_type))
        clnw_pkg::REQ_CMD: begin
          push_byte(1'b0, r.payload_byte);
        end
        clnw_pkg::REQ_DATA: begin
          push_byte(1'b1, r.payload_byte);
          n = chars_written + 7'd1;
          chars_written = n;
          if (n > clnw_pkg::SCROLL_START && n < clnw_pkg::SCROLL_PAGE) push_shifts(1);
          if (n == clnw_pkg::SCROLL_PAGE) push_shifts(16);
          if (n > clnw_pkg::SCROLL_ROW2) push_shifts(1);
          if (n > clnw_pkg::SCROLL_WRAP) begin
            push_shifts(16);
            chars_written = '0;
            push_byte(1'b0, clnw_pkg::ROW0_BASE);
          end
        end
        clnw_pkg::REQ_CLEAR: begin
          chars_written = '0;
          push_byte(1'b0, clnw_pkg::CMD_CLEAR);
        end
        clnw_pkg::REQ_MOVE: begin
          addr = (r.row_sel ? clnw_pkg::ROW1_BASE : clnw_pkg::ROW0_BASE) + r.column;
          push_byte(1'b0, addr);
        end
        default: begin
          push_byte(1'b0, r.payload_byte);
        end
      endcase
      expected_xfers[expected_xfers.size() - 1].last = 1'b1;
    endfunction

    function void check_xfer(clnw_pkg::xfer_t got);
      clnw_pkg::xfer_t exp_x;
      if (expected_xfers.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: transfer with nothing pending: rs=%0b nibble=%h last=%0b",
                   $time, got.reg_select, got.nibble, got.last);
      end else begin
        exp_x = expected_xfers.pop_front();
        if (got.reg_select !== exp_x.reg_select || got.nibble !== exp_x.nibble ||
            got.last !== exp_x.last) begin
          errors++;
          if (errors <= 10)
            $display("%0t: mismatch exp rs=%0b nibble=%h last=%0b %s",
                     $time, exp_x.reg_select, exp_x.nibble, exp_x.last,
                     $sformatf("got rs=%0b nibble=%h last=%0b",
                               got.reg_select, got.nibble, got.last));
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   idle_on = 1'b1;
  bit   hold_long = 1'b0;
  int   cycles = 0;

  clnw_req_if  req_ch ();
  clnw_xfer_if xfer_ch ();

  lcd_xfer_scoreboard sb = new();

  char_lcd_nibble_writer_autoscroll_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (xfer_ch)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("char_lcd_nibble_writer_autoscroll_top_tb: done, errors");
      $finish;
    end
  end

  // sample both handshakes with pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
      if (xfer_ch.valid && xfer_ch.ready) sb.check_xfer(xfer_ch.data);
    end
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    xfer_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_long) begin
        xfer_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_long = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        xfer_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      xfer_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic send_req(clnw_pkg::req_e kind, logic [7:0] payload, logic row,
                          logic [7:0] col);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= '{req_type: kind, payload_byte: payload, row_sel: row, column: col};
    do @(posedge clk_i); while (!(req_ch.valid && req_ch.ready));
  endtask

  // the first edge lets the sampler note the last accepted request
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_xfers.size() != 0);
  endtask

  initial begin
    int              sent;
    int              seg_left;
    bit              long_run;
    int              pick;
    clnw_pkg::req_e  kind;

    sent = 0;
    seg_left = 0;
    long_run = 1'b0;
    rst_ni = 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes and the corner cases of each request
    send_req(clnw_pkg::REQ_CMD,   8'h00, 1'b0, 8'h00);
    send_req(clnw_pkg::REQ_CMD,   8'hFF, 1'b1, 8'hFF);
    send_req(clnw_pkg::REQ_DATA,  8'h00, 1'b0, 8'h00);
    send_req(clnw_pkg::REQ_DATA,  8'hFF, 1'b1, 8'hFF);
    // raw clear byte must not reset the count
    send_req(clnw_pkg::REQ_CMD,   clnw_pkg::CMD_CLEAR, 1'b0, 8'h00);
    send_req(clnw_pkg::REQ_DATA,  8'hA5, 1'b0, 8'h00);
    send_req(clnw_pkg::REQ_CLEAR, 8'hFF, 1'b1, 8'hFF);
    send_req(clnw_pkg::REQ_DATA,  8'h5A, 1'b1, 8'h5A);
    send_req(clnw_pkg::REQ_MOVE,  8'hFF, 1'b0, 8'h00);
    send_req(clnw_pkg::REQ_MOVE,  8'h00, 1'b0, 8'h7F);
    send_req(clnw_pkg::REQ_MOVE,  8'h00, 1'b0, 8'hFF);
    send_req(clnw_pkg::REQ_MOVE,  8'h00, 1'b1, 8'h00);
    send_req(clnw_pkg::REQ_MOVE,  8'h00, 1'b1, 8'h3F);
    send_req(clnw_pkg::REQ_MOVE,  8'h00, 1'b1, 8'h40);
    send_req(clnw_pkg::REQ_MOVE,  8'hAA, 1'b1, 8'hFF);
    send_req(clnw_pkg::REQ_DATA,  8'h3C, 1'b0, 8'h00);
    send_req(clnw_pkg::REQ_CLEAR, 8'h00, 1'b0, 8'h00);
    send_req(clnw_pkg::REQ_CMD,   clnw_pkg::CMD_SHIFT_LEFT, 1'b1, 8'h80);
    send_req(clnw_pkg::REQ_DATA,  8'hC3, 1'b0, 8'h00);
    wait_drained();

    // mostly long character runs so the count climbs through every scroll band
    while (sent < RANDOM_ITEMS) begin
      if (sent == QUIET_FROM) idle_on = 1'b0;
      if (sent == 120) hold_long = 1'b1;
      if (sent == 200) wait_drained();
      if (seg_left == 0) begin
        long_run = $urandom_range(0, 9) < 7;
        seg_left = long_run ? $urandom_range(20, 90) : $urandom_range(1, 6);
      end
      seg_left--;
      pick = $urandom_range(0, 19);
      if (long_run)
        kind = (pick == 0) ? clnw_pkg::REQ_CMD :
               (pick == 1) ? clnw_pkg::REQ_MOVE : clnw_pkg::REQ_DATA;
      else
        kind = clnw_pkg::req_e'($urandom_range(0, 3));
      send_req(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               8'($urandom_range(0, 255)));
      sent++;
    end

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_xfers.size() == 0) begin
      $display("char_lcd_nibble_writer_autoscroll_top_tb: done, clean");
    end else begin
      $display("char_lcd_nibble_writer_autoscroll_top_tb: done, errors");
    end
    $finish;
  end

endmodule
